// File: hdl/nfs_pkg.sv
// ----------------------------------------------------------------------------
// nfs_pkg
// shared types and constants for the newest-first top-k selector
// ----------------------------------------------------------------------------
package nfs_pkg;

    // number of cells in the chain, 1 to 64
    localparam int LIMIT  = 8;
    // width of a count that may reach LIMIT
    localparam int CNT_W  = $clog2(LIMIT + 1);
    // width of the seen counter, saturates at LIMIT+1
    localparam int SEEN_W = $clog2(LIMIT + 2);

    localparam int ID_W   = 16;
    localparam int TIME_W = 32;
    localparam int DUR_W  = 32;
    localparam int MAX_W  = 7;

    localparam logic [MAX_W-1:0] MAX_RESET = MAX_W'(8);

    // beat kinds on the input side
    localparam logic CMD_OFFER  = 1'b0;
    localparam logic CMD_FINISH = 1'b1;

    // register index of max_entries
    localparam logic REG_MAX_ENTRIES = 1'b0;

    typedef struct packed {
        logic [DUR_W-1:0]  dur;
        logic [TIME_W-1:0] created;
        logic [ID_W-1:0]   id;
    } t_rec;

    typedef struct packed {
        logic offer;      // insert the offered record in this cycle
        logic pop;        // readout: pull from the next cell
        logic occ;        // this cell holds a live entry
        logic take_prev;  // previous cell also takes
    } t_cell_ctl;

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } t_state;

endpackage

// File: hdl/nfs_cell.sv
// ----------------------------------------------------------------------------
// nfs_cell
// one compare-and-shift cell of the sorted chain
// ----------------------------------------------------------------------------
module nfs_cell
    import nfs_pkg::*;
(
    input  logic      i_clk,
    input  t_cell_ctl i_ctl,
    input  t_rec      i_new,
    input  t_rec      i_prev,
    input  t_rec      i_next,
    output t_rec      o_rec,
    output logic      o_take
);

    t_rec r_rec;
    logic w_newer;

    // newer: larger time, or equal time and larger id
    assign w_newer = {i_new.created, i_new.id} > {r_rec.created, r_rec.id};
    // an empty cell is outranked by anything
    assign o_take  = i_ctl.occ ? w_newer : 1'b1;
    assign o_rec   = r_rec;

    always_ff @(posedge i_clk) begin
        if (i_ctl.pop) begin
            r_rec <= i_next;
        end else if (i_ctl.offer && o_take) begin
            r_rec <= i_ctl.take_prev ? i_prev : i_new;
        end
    end

endmodule

// File: hdl/newest_first_top_k_selector.sv
// ----------------------------------------------------------------------------
// newest_first_top_k_selector
// keeps the newest records of a stream in a sorted chain of cells and
// emits them newest first on a finish beat
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake                 payload
//  s_*       in   s_tvalid / s_tready       tuser: command
//                                           tdata: rec_id, created_time, duration
//  m_*       out  m_tvalid / m_tready       tuser: entry_valid, more_available
//                                           tdata: out_id, out_created, out_duration
//                                           tlast: last_of_run
//  apb       in   psel & penable & pwrite   reg 0 at byte address 0: max_entries
//
//  on an offer beat every cell compares the record with its own
//  entry at once and the chain shifts down past the insertion point
//  a finish beat starts a readout of max(held, 1) beats, one per cycle while
//  m_tready is high, pulling the chain up toward cell 0; no beat is taken on
//  s_* until the last result is in the output register
//  the output register lets new offers in while the last result waits
//  synchronous active-low reset clears counts, state and the output valid;
//  max_entries resets to 8
// ----------------------------------------------------------------------------
module newest_first_top_k_selector
    import nfs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // [15:0] rec_id, [47:16] created_time, [79:48] duration
    input  logic [0:0]  s_tuser,   // [0] command

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // [15:0] out_id, [47:16] out_created, [79:48] out_duration
    output logic [1:0]  m_tuser,   // [0] entry_valid, [1] more_available
    output logic        m_tlast,   // last_of_run

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // config and control state
    logic [MAX_W-1:0]  r_max;
    logic [CNT_W-1:0]  r_held;
    logic [SEEN_W-1:0] r_seen;
    logic [CNT_W-1:0]  r_rem;
    logic              r_empty;
    logic              r_more;
    t_state            r_state, n_state;

    // output register
    logic              r_mvalid;
    t_rec              r_mrec;
    logic              r_mentry;
    logic              r_mmore;
    logic              r_mlast;

    logic [CNT_W-1:0]  w_m;
    logic [CNT_W-1:0]  w_held;
    logic              w_acc;
    logic              w_acc_offer;
    logic              w_acc_finish;
    logic              w_place;
    logic              w_offer;
    logic              w_ofree;
    logic              w_emit;
    logic              w_emit_last;
    logic              w_cfg_wr;
    t_rec              w_new;

    t_rec              w_rec  [LIMIT];
    logic [LIMIT-1:0]  w_take;
    logic [LIMIT-1:0]  w_ltm;

    // ---------------- apb register ----------------
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && (paddr[2] == REG_MAX_ENTRIES);
    assign prdata   = (paddr[2] == REG_MAX_ENTRIES) ? {{(32-MAX_W){1'b0}}, r_max} : 32'd0;

    // effective limit and held count under that limit
    assign w_m    = (r_max < MAX_W'(LIMIT)) ? CNT_W'(r_max) : CNT_W'(LIMIT);
    assign w_held = (r_held < w_m) ? r_held : w_m;

    assign w_new.id      = s_tdata[15:0];
    assign w_new.created = s_tdata[47:16];
    assign w_new.dur     = s_tdata[79:48];

    assign w_acc        = s_tvalid && s_tready;
    assign w_acc_offer  = w_acc && (s_tuser[0] == CMD_OFFER);
    assign w_acc_finish = w_acc && (s_tuser[0] == CMD_FINISH);

    // ---------------- cell chain ----------------
    // take bits are monotone along the chain, so the record lands inside the
    // limit exactly when some cell below the limit takes
    assign w_place = |(w_take & w_ltm);
    assign w_offer = w_acc_offer && w_place;

    for (genvar gi = 0; gi < LIMIT; gi++) begin : g_cell
        t_cell_ctl w_ctl;

        assign w_ltm[gi]       = CNT_W'(gi) < w_m;
        assign w_ctl.offer     = w_offer;
        assign w_ctl.pop       = w_emit && !r_empty;
        assign w_ctl.occ       = CNT_W'(gi) < w_held;
        assign w_ctl.take_prev = (gi == 0) ? 1'b0 : w_take[(gi == 0) ? 0 : gi-1];

        nfs_cell u_cell (
            .i_clk  (i_clk),
            .i_ctl  (w_ctl),
            .i_new  (w_new),
            .i_prev (w_rec[(gi == 0) ? 0 : gi-1]),
            .i_next (w_rec[(gi == LIMIT-1) ? gi : gi+1]),
            .o_rec  (w_rec[gi]),
            .o_take (w_take[gi])
        );
    end

    // ---------------- control fsm ----------------
    assign w_ofree     = !r_mvalid || m_tready;
    assign w_emit_last = r_empty || (r_rem == CNT_W'(1));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_acc_finish) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (w_ofree && w_emit_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready = 1'b0;
        w_emit   = 1'b0;
        unique case (r_state)
            ST_IDLE: s_tready = 1'b1;
            ST_EMIT: w_emit   = w_ofree;
            default: begin
                s_tready = 1'b0;
                w_emit   = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_max   <= MAX_RESET;
            r_held  <= '0;
            r_seen  <= '0;
            r_rem   <= '0;
            r_empty <= 1'b0;
            r_more  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_cfg_wr) begin
                r_max <= pwdata[MAX_W-1:0];
            end
            if (w_acc_offer) begin
                if (r_seen < SEEN_W'(LIMIT + 1)) begin
                    r_seen <= r_seen + SEEN_W'(1);
                end
                if (w_place && (w_held < w_m)) begin
                    r_held <= w_held + CNT_W'(1);
                end else begin
                    r_held <= w_held;
                end
            end else if (w_acc_finish) begin
                r_held  <= '0;
                r_seen  <= '0;
                r_rem   <= w_held;
                r_empty <= (w_held == '0);
                r_more  <= (w_m != '0) && (SEEN_W'(w_m) < r_seen);
            end else if (w_emit && !r_empty) begin
                r_rem <= r_rem - CNT_W'(1);
            end
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mvalid <= 1'b0;
        end else if (w_emit) begin
            r_mvalid <= 1'b1;
        end else if (m_tready) begin
            r_mvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_mmore <= r_more;
            r_mlast <= w_emit_last;
            if (r_empty) begin
                r_mrec   <= '0;
                r_mentry <= 1'b0;
            end else begin
                r_mrec   <= w_rec[0];
                r_mentry <= 1'b1;
            end
        end
    end

    assign m_tvalid = r_mvalid;
    assign m_tdata  = {r_mrec.dur, r_mrec.created, r_mrec.id};
    assign m_tuser  = {r_mmore, r_mentry};
    assign m_tlast  = r_mlast;

endmodule

// File: dv/newest_first_top_k_selector_checker.sv
// ----------------------------------------------------------------------------
// newest_first_top_k_selector_checker
// watches the apb port and both stream channels, keeps its own newest-first
// list and compares every output beat with the first entry still due
// ----------------------------------------------------------------------------
module newest_first_top_k_selector_checker
    import nfs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [79:0] i_s_tdata,   // [15:0] rec_id, [47:16] created_time, [79:48] duration
    input  logic [0:0]  i_s_tuser,   // [0] command

    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [79:0] i_m_tdata,   // [15:0] out_id, [47:16] out_created, [79:48] out_duration
    input  logic [1:0]  i_m_tuser,   // [0] entry_valid, [1] more_available
    input  logic        i_m_tlast,   // last_of_run

    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    input  logic        i_pready,

    output int          o_fail_count,
    output int          o_pending,
    output int          o_checked
);

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic              valid;
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] created;
        logic [DUR_W-1:0]  dur;
        logic              more;
        logic              last;
    } t_entry_beat;

    // sorted copy of the store, newest at index 0
    logic [ID_W-1:0]   rank_id   [LIMIT];
    logic [TIME_W-1:0] rank_time [LIMIT];
    logic [DUR_W-1:0]  rank_dur  [LIMIT];
    int                live_count;
    int                offer_count;
    logic [MAX_W-1:0]  limit_reg;

    t_entry_beat newest_list_due [$];

    int fail_total    = 0;
    int checked_total = 0;
    int due_total     = 0;

    assign o_fail_count = fail_total;
    assign o_pending    = due_total;
    assign o_checked    = checked_total;

    task automatic report(string field, logic [63:0] want, logic [63:0] got);
        $display("mismatch on %s at %0t: want %0h got %0h", field, $realtime, want, got);
        fail_total++;
    endtask

    function automatic int kept_cap();
        return (int'(limit_reg) < LIMIT) ? int'(limit_reg) : LIMIT;
    endfunction

    function automatic logic is_newer(logic [TIME_W-1:0] t_a, logic [ID_W-1:0] id_a,
                                      logic [TIME_W-1:0] t_b, logic [ID_W-1:0] id_b);
        return (t_a > t_b) || ((t_a == t_b) && (id_a > id_b));
    endfunction

    task automatic take_record(logic [ID_W-1:0] id, logic [TIME_W-1:0] t,
                               logic [DUR_W-1:0] d);
        int m;
        int live;
        int pos;
        m    = kept_cap();
        live = (live_count < m) ? live_count : m;
        pos  = 0;
        if (offer_count < LIMIT + 1) begin
            offer_count++;
        end
        while (pos < live && !is_newer(t, id, rank_time[pos], rank_id[pos])) begin
            pos++;
        end
        // no place inside the limit: dropped, but a lowered limit still trims
        if (pos >= m) begin
            live_count = live;
            return;
        end
        if (live < m) begin
            live++;
        end
        for (int j = live - 1; j > pos; j--) begin
            rank_id[j]   = rank_id[j-1];
            rank_time[j] = rank_time[j-1];
            rank_dur[j]  = rank_dur[j-1];
        end
        rank_id[pos]   = id;
        rank_time[pos] = t;
        rank_dur[pos]  = d;
        live_count     = live;
    endtask

    task automatic flush_newest_list();
        int          m;
        int          live;
        logic        more;
        t_entry_beat b;
        m    = kept_cap();
        live = (live_count < m) ? live_count : m;
        more = (m > 0) && (offer_count > m);
        if (live == 0) begin
            b = '{valid: 1'b0, id: '0, created: '0, dur: '0, more: more, last: 1'b1};
            newest_list_due.push_back(b);
        end else begin
            for (int k = 0; k < live; k++) begin
                b = '{valid: 1'b1, id: rank_id[k], created: rank_time[k], dur: rank_dur[k],
                      more: more, last: (k == live - 1)};
                newest_list_due.push_back(b);
            end
        end
        live_count  = 0;
        offer_count = 0;
    endtask

    task automatic check_result_beat();
        t_entry_beat want;
        if (newest_list_due.size() == 0) begin
            report("beat with nothing due", 64'd0, i_m_tdata[63:0]);
            return;
        end
        want = newest_list_due.pop_front();
        checked_total++;
        if (i_m_tuser[0] !== want.valid)
            report("entry_valid", 64'(want.valid), 64'(i_m_tuser[0]));
        if (i_m_tdata[15:0] !== want.id)
            report("out_id", 64'(want.id), 64'(i_m_tdata[15:0]));
        if (i_m_tdata[47:16] !== want.created)
            report("out_created", 64'(want.created), 64'(i_m_tdata[47:16]));
        if (i_m_tdata[79:48] !== want.dur)
            report("out_duration", 64'(want.dur), 64'(i_m_tdata[79:48]));
        if (i_m_tuser[1] !== want.more)
            report("more_available", 64'(want.more), 64'(i_m_tuser[1]));
        if (i_m_tlast !== want.last)
            report("last_of_run", 64'(want.last), 64'(i_m_tlast));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            limit_reg   = MAX_RESET;
            live_count  = 0;
            offer_count = 0;
            newest_list_due.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready
                && i_paddr[2] == REG_MAX_ENTRIES && i_paddr[1:0] == 2'b00) begin
                limit_reg = i_pwdata[MAX_W-1:0];
            end
            if (i_m_tvalid && i_m_tready) begin
                check_result_beat();
            end
            if (i_s_tvalid && i_s_tready) begin
                if (i_s_tuser[0] == CMD_OFFER)
                    take_record(i_s_tdata[15:0], i_s_tdata[47:16], i_s_tdata[79:48]);
                else
                    flush_newest_list();
            end
        end
        due_total = newest_list_due.size();
    end

endmodule

// File: dv/newest_first_top_k_selector_test.sv
// ----------------------------------------------------------------------------
// newest_first_top_k_selector_test
// drives offer and finish beats and max_entries writes into the selector,
// with random gaps on both stream sides, and reports the checker's verdict
// ----------------------------------------------------------------------------
module newest_first_top_k_selector_test;

    import nfs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // far above the slowest legal run
    localparam int CYCLE_CAP    = 200000;
    localparam int RANDOM_BEATS = 100;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;

    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [79:0] s_tdata  = '0;   // [15:0] rec_id, [47:16] created_time, [79:48] duration
    logic [0:0]  s_tuser  = '0;   // [0] command

    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [79:0] m_tdata;         // [15:0] out_id, [47:16] out_created, [79:48] out_duration
    logic [1:0]  m_tuser;         // [0] entry_valid, [1] more_available
    logic        m_tlast;         // last_of_run

    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [2:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    int fail_count;
    int pending;
    int checked;

    int   cycles    = 0;
    int   sent      = 0;
    int   finishes  = 0;
    // when set, neither side idles
    logic calm      = 1'b0;

    newest_first_top_k_selector u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    newest_first_top_k_selector_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .i_m_tlast    (m_tlast),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_pready     (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // watchdog: a hung handshake or a result that never comes ends up here
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_CAP) begin
            $display("tb: failure");
            $finish;
        end
    end

    // receiver backpressure, about 27 percent of cycles stalled
    always @(negedge i_clk) begin
        m_tready <= calm || ($urandom_range(0, 99) >= 27);
    end

    // one input beat; entered and left at a falling edge
    task automatic send_beat(logic cmd, logic [ID_W-1:0] id, logic [TIME_W-1:0] t,
                             logic [DUR_W-1:0] d);
        // random gap before the beat; valid only drops when a gap is taken
        if (!calm && $urandom_range(0, 99) < 27) begin
            s_tvalid <= 1'b0;
            do @(negedge i_clk); while ($urandom_range(0, 99) < 27);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {d, t, id};
        do @(posedge i_clk); while (!s_tready);
        @(negedge i_clk);
        sent++;
        if (cmd == CMD_FINISH)
            finishes++;
    endtask

    task automatic offer(logic [ID_W-1:0] id, logic [TIME_W-1:0] t, logic [DUR_W-1:0] d);
        send_beat(CMD_OFFER, id, t, d);
    endtask

    // payload of a finish beat is don't-care, so it carries noise
    task automatic finish_run();
        send_beat(CMD_FINISH, ID_W'($urandom), $urandom, $urandom);
    endtask

    // wait until every due result is out, then let the last offer settle
    task automatic wait_quiet();
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // setup phase then access phase; write lands when pready is high
    task automatic write_limit(int value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'(4 * REG_MAX_ENTRIES);
        pwdata  <= 32'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // narrow ranges make ties on time and id likely, wide ones reach the top bits
    function automatic logic [TIME_W-1:0] pick_time();
        case ($urandom_range(0, 3))
            0:       return TIME_W'($urandom_range(0, 5));
            1:       return 32'hFFFF_FFF0 + TIME_W'($urandom_range(0, 15));
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [ID_W-1:0] pick_id();
        if ($urandom_range(0, 1) == 0)
            return ID_W'($urandom_range(0, 3));
        return ID_W'($urandom);
    endfunction

    function automatic int pick_limit();
        case ($urandom_range(0, 6))
            0:       return 0;
            1:       return 64;
            2:       return LIMIT;
            3:       return LIMIT + 1;
            4:       return $urandom_range(0, 64);
            default: return $urandom_range(1, LIMIT);
        endcase
    endfunction

    initial begin
        int phase;
        int n_offers;
        int directed;

        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // --- directed part, reset limit of 8 ---
        // finish on an empty store gives one empty beat
        finish_run();
        // field extremes, a tie broken by id, an exact duplicate, then overflow
        offer(16'h0000, 32'h0000_0000, 32'h0000_0000);
        offer(16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        offer(16'h0010, 32'd1000, 32'hA5A5_A5A5);
        offer(16'h0011, 32'd1000, 32'h5A5A_5A5A);
        offer(16'h0011, 32'd1000, 32'h1234_5678);
        offer(16'h0005, 32'd500, 32'd7);
        offer(16'h8000, 32'h8000_0000, 32'd9);
        offer(16'h0001, 32'd2000, 32'd11);
        // ninth record: store full, oldest falls off, more flag set
        offer(16'h0002, 32'd2000, 32'd12);
        // older than everything held: dropped
        offer(16'h0003, 32'd0, 32'd13);
        finish_run();

        // zero limit drops everything and never sets the more flag
        wait_quiet();
        write_limit(0);
        offer(16'h1234, 32'd77, 32'd1);
        finish_run();

        // limit above the chain depth, then lowered while entries are held
        wait_quiet();
        write_limit(64);
        offer(16'd5, 32'd300, 32'd1);
        offer(16'd6, 32'd100, 32'd2);
        offer(16'd7, 32'd200, 32'd3);
        wait_quiet();
        write_limit(2);
        offer(16'd8, 32'd50, 32'd4);
        finish_run();

        // single entry kept
        wait_quiet();
        write_limit(1);
        offer(16'd9, 32'd10, 32'd5);
        offer(16'd10, 32'd20, 32'd6);
        finish_run();

        // --- random part: phases of offers, mostly closed by a finish ---
        // a phase without finish leaves entries held across the next limit change
        directed = sent;
        phase    = 0;
        while (sent < directed + RANDOM_BEATS) begin
            wait_quiet();
            calm = (phase >= 3 && phase <= 5);
            write_limit(pick_limit());
            n_offers = $urandom_range(0, 12);
            repeat (n_offers)
                offer(pick_id(), pick_time(), $urandom);
            if ($urandom_range(0, 4) != 0)
                finish_run();
            // back-to-back finishes now and then
            if ($urandom_range(0, 7) == 0)
                finish_run();
            phase++;
        end
        finish_run();
        calm = 1'b0;

        // drain, then wait for stray beats
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge i_clk);
        repeat (10) @(negedge i_clk);

        $display("run covered %0d input beats with %0d finish runs, %0d result beats checked",
                 sent, finishes, checked);
        $display("limits swept over zero, one, the chain depth, one above it and 64");
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// File: files.f
hdl/nfs_pkg.sv
hdl/nfs_cell.sv
hdl/newest_first_top_k_selector.sv
dv/newest_first_top_k_selector_checker.sv
dv/newest_first_top_k_selector_test.sv
